>>> design/pcm8u_pkg.sv
// pcm8u_pkg: shared types, constants and helpers of the pcm8 linear upsampler
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
package pcm8u_pkg;

	localparam int FRAC_WIDTH_DEF = 16;
	localparam int MAX_RESULTS    = 64;
	localparam int NCNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int STEP_W         = 17;
	localparam int COUNT_W        = 24;
	localparam int BYTE_W         = 8;
	localparam int PCM_W          = 16;
	localparam int DIFF_W         = PCM_W + 1;
	localparam int LIFT           = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 24;

	localparam logic [BYTE_W-1:0]  CENTRE     = 8'd128;
	localparam logic [STEP_W-1:0]  STEP_RESET = 17'd10465;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_EMIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic emit;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic go;
		logic more;
		logic out_free;
	} dp_status_t;

	// (b - 128) << 8 as a signed 16-bit sample
	function automatic logic signed [PCM_W-1:0] centre_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W:0] d;
		d = {1'b0, b} - {1'b0, CENTRE};
		return {d[PCM_W-LIFT-1:0], {LIFT{1'b0}}};
	endfunction

endpackage

>>> design/pcm8u_ctrl.sv
// pcm8u_ctrl: sequencing state machine of the pcm8 linear upsampler
// depends on pcm8u_pkg for the state type and the command and status structs
`timescale 1ns / 1ps
module pcm8u_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  pcm8u_pkg::dp_status_t  sts,
	output logic                   s_tready,
	output pcm8u_pkg::ctrl_cmd_t   cmd
);
	import pcm8u_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.go ? ST_MUL : ST_FIN;
			end
			ST_MUL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) state_d = sts.more ? ST_MUL : ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_CHECK: begin
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/pcm8u_datapath.sv
// pcm8u_datapath: config registers, phase accumulator, interpolation multiply
// and output register; depends on pcm8u_pkg
`timescale 1ns / 1ps
module pcm8u_datapath #(
	parameter int FRAC_WIDTH = pcm8u_pkg::FRAC_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcm8u_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcm8u_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [pcm8u_pkg::BYTE_W-1:0]        src_byte,
	input  logic                                src_last,
	input  pcm8u_pkg::ctrl_cmd_t                cmd,
	output pcm8u_pkg::dp_status_t               sts,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [pcm8u_pkg::PCM_W-1:0]         m_tdata,
	output logic                                m_tlast
);
	import pcm8u_pkg::*;

	localparam int PH_W   = FRAC_WIDTH + 2;
	localparam int CMP_W  = (PH_W > STEP_W) ? PH_W : STEP_W;
	localparam int PROD_W = PH_W + DIFF_W;
	localparam logic [PH_W-1:0] UNIT = PH_W'(1) << FRAC_WIDTH;

	logic [STEP_W-1:0]        step_q;
	logic [COUNT_W-1:0]       count_q;
	logic [BYTE_W-1:0]        held_q;
	logic                     have_held_q;
	logic [PH_W-1:0]          phase_q;
	logic [COUNT_W-1:0]       emitted_q;
	logic                     last_q;
	logic                     mode_b_q;
	logic [NCNT_W-1:0]        n_q;
	logic                     out_valid_q;
	logic [BYTE_W-1:0]        byte_q;
	logic signed [PCM_W-1:0]  cur_q;
	logic signed [PCM_W-1:0]  nxt_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [PCM_W-1:0]         out_data_q;
	logic                     out_last_q;

	logic [PH_W-1:0]          step_eff;
	logic [PH_W-1:0]          phase_sum;
	logic [PH_W-1:0]          phase_new;
	logic                     wrap;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PH_W-1:0]   weight;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_sh;
	logic [PCM_W-1:0]         pcm_d;
	logic [COUNT_W-1:0]       emitted_inc;
	logic                     more;

	always_comb begin
		step_eff  = (CMP_W'(step_q) > CMP_W'(UNIT)) ? UNIT : PH_W'(step_q);
		phase_sum = phase_q + step_eff;
		wrap      = phase_sum > UNIT;
		phase_new = wrap ? (phase_sum - UNIT) : phase_sum;

		diff    = $signed({nxt_q[PCM_W-1], nxt_q}) - $signed({cur_q[PCM_W-1], cur_q});
		weight  = $signed({1'b0, phase_q[FRAC_WIDTH:0]});
		prod_d  = PROD_W'(weight) * PROD_W'(diff);
		// arithmetic shift gives the floor of the scaled product
		prod_sh = prod_s1 >>> FRAC_WIDTH;
		pcm_d   = cur_q + prod_sh[PCM_W-1:0];

		emitted_inc = emitted_q + COUNT_W'(1);
		more = (n_q != NCNT_W'(MAX_RESULTS - 1)) && (emitted_inc < count_q)
			&& (!wrap || (!mode_b_q && last_q));

		sts.go       = (emitted_q < count_q) && (have_held_q || last_q);
		sts.more     = more;
		sts.out_free = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_RESET;
			count_q     <= '0;
			held_q      <= CENTRE;
			have_held_q <= 1'b0;
			phase_q     <= '0;
			emitted_q   <= '0;
			last_q      <= 1'b0;
			mode_b_q    <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PHASE_STEP:   step_q  <= cfg_data[STEP_W-1:0];
					REG_OUTPUT_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				last_q   <= src_last;
				mode_b_q <= !have_held_q;
				n_q      <= '0;
			end
			if (cmd.emit) begin
				phase_q   <= phase_new;
				emitted_q <= emitted_inc;
				n_q       <= n_q + NCNT_W'(1);
				if (wrap && !mode_b_q) mode_b_q <= 1'b1;
			end
			if (cmd.finish) begin
				if (last_q) begin
					held_q      <= CENTRE;
					have_held_q <= 1'b0;
					phase_q     <= '0;
					emitted_q   <= '0;
				end else begin
					held_q      <= byte_q;
					have_held_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= src_byte;
			cur_q  <= have_held_q ? centre_byte(held_q) : centre_byte(src_byte);
			nxt_q  <= centre_byte(src_byte);
		end
		if (cmd.mul) begin
			prod_s1 <= prod_d;
		end
		if (cmd.emit) begin
			out_data_q <= pcm_d;
			out_last_q <= !more;
			// phase passed one unit: the final sample now runs against itself
			if (wrap && !mode_b_q) cur_q <= nxt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

>>> design/pcm8_linear_upsampler_core.sv
// pcm8_linear_upsampler_core: top level of the pcm8 linear upsampler
// instantiates pcm8u_ctrl and pcm8u_datapath; depends on pcm8u_pkg
//
// channel   dir  signals                          content
// s_axis    in   s_tvalid s_tready s_tdata s_tlast source byte, last source sample
// m_axis    out  m_tvalid m_tready m_tdata m_tlast 16-bit sample, last of request
// cfg       in   cfg_we cfg_index cfg_data         0 phase_step, 1 output_count
//
// an input request is accepted in ST_IDLE and checked in ST_CHECK, then passes
// through ST_MUL and ST_EMIT once per output, and ends in ST_FIN
// the registered interpolation multiply followed by the add gives each output
// a multiply state and an emit state; a stalled m_tready holds the block in ST_EMIT
// arst_n clears state: phase_step 10465, output_count 0, nothing held
`timescale 1ns / 1ps
module pcm8_linear_upsampler_core #(
	parameter int FRAC_WIDTH = pcm8u_pkg::FRAC_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pcm8u_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcm8u_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pcm8u_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] source_byte
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pcm8u_pkg::PCM_W-1:0]       m_tdata,   // [15:0] pcm_value
	output logic                              m_tlast
);
	import pcm8u_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	pcm8u_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	pcm8u_datapath #(
		.FRAC_WIDTH (FRAC_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_byte  (s_tdata),
		.src_last  (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

`ifndef NO_ASSERTIONS
	a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !s_tready)
		else $error("request accepted during emit");

	a_more_goes_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.more |=> cmd.mul)
		else $error("pending output not followed by multiply");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> s_tready)
		else $error("finish not followed by idle");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted sample not presented");
`endif

endmodule
